/* design/rtss_pkg.sv */
// Shared types and codes for the I2C register transfer sequencer.
// No dependencies; imported by every module of the block.
package rtss_pkg;

	localparam int CNT_W = 5;

	// request kinds
	localparam logic [1:0] REQ_TICK    = 2'd0;
	localparam logic [1:0] REQ_LOAD    = 2'd1;
	localparam logic [1:0] REQ_RELEASE = 2'd2;

	// commands seen on a tick while idle
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_WRITE = 2'd2;

	// bus actions
	localparam logic [3:0] ACT_NONE         = 4'd0;
	localparam logic [3:0] ACT_START_SEND   = 4'd1;
	localparam logic [3:0] ACT_SEND         = 4'd2;
	localparam logic [3:0] ACT_RESTART_SEND = 4'd3;
	localparam logic [3:0] ACT_CLEAR        = 4'd4;
	localparam logic [3:0] ACT_CLEAR_RX     = 4'd5;
	localparam logic [3:0] ACT_RX_ACK       = 4'd6;
	localparam logic [3:0] ACT_RX_NACK      = 4'd7;
	localparam logic [3:0] ACT_STOP_CAPTURE = 4'd8;
	localparam logic [3:0] ACT_CAPTURE      = 4'd9;
	localparam logic [3:0] ACT_STOP         = 4'd10;

	// transfer status
	localparam logic [2:0] STAT_IDLE       = 3'd0;
	localparam logic [2:0] STAT_READING    = 3'd1;
	localparam logic [2:0] STAT_READ_DONE  = 3'd2;
	localparam logic [2:0] STAT_WRITING    = 3'd3;
	localparam logic [2:0] STAT_WRITE_DONE = 3'd4;

	localparam logic [7:0] DEV_READ_BIT = 8'h01;

	typedef struct packed {
		logic [1:0]       req_type;
		logic [1:0]       cmd;
		logic [7:0]       dev_addr;
		logic [7:0]       reg_addr;
		logic [CNT_W-1:0] byte_count;
		logic [3:0]       buf_index;
		logic [7:0]       buf_value;
		logic             xfer_done;
		logic [7:0]       rx_byte;
	} item_t;

	typedef struct packed {
		logic [3:0] bus_action;
		logic [7:0] tx_byte;
		logic       read_valid;
		logic [3:0] read_index;
		logic [7:0] read_data;
		logic [2:0] status;
		logic       done_pulse;
	} result_t;

	// write buffer port: load from the item, read at the next write position
	typedef struct packed {
		logic             we;
		logic [3:0]       waddr;
		logic [7:0]       wdata;
		logic [CNT_W-1:0] raddr;
	} wbuf_req_t;

endpackage

/* design/i2c_register_transfer_sequencer.sv */
// Top level of the I2C register transfer sequencer: input register, step core,
// write buffer and result register. Depends on rtss_pkg, rtss_core, rtss_wbuf.
//
//  channel | handshake            | payload
//  --------+----------------------+----------------------------------------------
//  in      | in_valid / in_ready  | req_type cmd dev_addr reg_addr byte_count
//          |                      | buf_index buf_value xfer_done rx_byte
//  out     | out_valid / out_ready| bus_action tx_byte read_valid read_index
//          |                      | read_data status done_pulse
//
// One transaction per cycle sustained while out_ready is held; the input is registered
// first, and one step of the sequencer then goes into the result register, which
// drives the outputs.
// The input side keeps accepting while a result waits, until both registers are full.
// arst_n clears the step state, counters, latched fields and status; the write
// buffer is not cleared and holds whatever was loaded.
module i2c_register_transfer_sequencer import rtss_pkg::*; #(
	parameter int BUF_DEPTH = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] req_type,
	input  logic [1:0] cmd,
	input  logic [7:0] dev_addr,
	input  logic [7:0] reg_addr,
	input  logic [4:0] byte_count,
	input  logic [3:0] buf_index,
	input  logic [7:0] buf_value,
	input  logic       xfer_done,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [3:0] bus_action,
	output logic [7:0] tx_byte,
	output logic       read_valid,
	output logic [3:0] read_index,
	output logic [7:0] read_data,
	output logic [2:0] status,
	output logic       done_pulse
);

	logic      valid_s1;
	item_t     item_s1;
	logic      adv;
	result_t   res;
	result_t   res_q;
	logic      out_valid_q;
	wbuf_req_t wbuf_req;
	logic [7:0] wbuf_rdata;

	assign adv      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.req_type   <= req_type;
			item_s1.cmd        <= cmd;
			item_s1.dev_addr   <= dev_addr;
			item_s1.reg_addr   <= reg_addr;
			item_s1.byte_count <= byte_count;
			item_s1.buf_index  <= buf_index;
			item_s1.buf_value  <= buf_value;
			item_s1.xfer_done  <= xfer_done;
			item_s1.rx_byte    <= rx_byte;
		end
		if (adv) begin
			res_q <= res;
		end
	end

	rtss_core #(
		.BUF_DEPTH(BUF_DEPTH)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (adv),
		.item      (item_s1),
		.wbuf_rdata(wbuf_rdata),
		.wbuf_req  (wbuf_req),
		.res       (res)
	);

	rtss_wbuf #(
		.BUF_DEPTH(BUF_DEPTH)
	) u_wbuf (
		.clk  (clk),
		.req  (wbuf_req),
		.rdata(wbuf_rdata)
	);

	assign out_valid  = out_valid_q;
	assign bus_action = res_q.bus_action;
	assign tx_byte    = res_q.tx_byte;
	assign read_valid = res_q.read_valid;
	assign read_index = res_q.read_index;
	assign read_data  = res_q.read_data;
	assign status     = res_q.status;
	assign done_pulse = res_q.done_pulse;

endmodule

/* design/rtss_wbuf.sv */
// Write data buffer of the sequencer: one write port, one registered read port.
// Depends on rtss_pkg.
module rtss_wbuf import rtss_pkg::*; #(
	parameter int BUF_DEPTH = 16
) (
	input  logic      clk,
	input  wbuf_req_t req,
	output logic [7:0] rdata
);

	localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

	logic [7:0]    mem [BUF_DEPTH];
	logic [7:0]    rdata_q;
	logic [AW-1:0] wa;
	logic [AW-1:0] ra;
	logic          wr_ok;

	assign wa    = AW'(req.waddr);
	assign ra    = AW'(req.raddr);
	assign wr_ok = req.we && (int'(req.waddr) < BUF_DEPTH);

	// read data always tracks the entry at the next write position,
	// with a same-cycle load forwarded
	always_ff @(posedge clk) begin
		if (wr_ok) begin
			mem[wa] <= req.wdata;
		end
		if (wr_ok && (wa == ra)) begin
			rdata_q <= req.wdata;
		end else begin
			rdata_q <= mem[ra];
		end
	end

	assign rdata = rdata_q;

endmodule

/* design/rtss_core.sv */
// Step sequencer: state registers and the per-transaction next-state and result logic.
// Depends on rtss_pkg; reads the write buffer through rtss_wbuf.
module rtss_core import rtss_pkg::*; #(
	parameter int BUF_DEPTH = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fire,
	input  item_t      item,
	input  logic [7:0] wbuf_rdata,
	output wbuf_req_t  wbuf_req,
	output result_t    res
);

	localparam logic [4:0] ST_IDLE         = 5'd0;
	localparam logic [4:0] ST_RD_START     = 5'd1;
	localparam logic [4:0] ST_RD_WAIT_DEV  = 5'd2;
	localparam logic [4:0] ST_RD_REG       = 5'd3;
	localparam logic [4:0] ST_RD_WAIT_REG  = 5'd4;
	localparam logic [4:0] ST_RD_RESTART   = 5'd5;
	localparam logic [4:0] ST_RD_WAIT_RS   = 5'd6;
	localparam logic [4:0] ST_RD_ARM       = 5'd7;
	localparam logic [4:0] ST_RD_WAIT_BYTE = 5'd8;
	localparam logic [4:0] ST_RD_CAPTURE   = 5'd9;
	localparam logic [4:0] ST_RD_FINISH    = 5'd10;
	localparam logic [4:0] ST_WR_START     = 5'd11;
	localparam logic [4:0] ST_WR_WAIT_DEV  = 5'd12;
	localparam logic [4:0] ST_WR_REG       = 5'd13;
	localparam logic [4:0] ST_WR_WAIT_REG  = 5'd14;
	localparam logic [4:0] ST_WR_DATA      = 5'd15;
	localparam logic [4:0] ST_WR_WAIT_DATA = 5'd16;
	localparam logic [4:0] ST_WR_FINISH    = 5'd17;

	logic [4:0]       state_q, state_d;
	logic [CNT_W-1:0] rc_q, rc_d;
	logic [CNT_W-1:0] wc_q, wc_d;
	logic             lbf_q, lbf_d;
	logic [7:0]       dev_q, dev_d;
	logic [7:0]       rga_q, rga_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [2:0]       stat_q, stat_d;
	logic [CNT_W-1:0] rc_inc;
	logic [CNT_W-1:0] cnt_sat;

	assign rc_inc  = rc_q + 1'b1;
	assign cnt_sat = (int'(item.byte_count) > BUF_DEPTH) ? CNT_W'(BUF_DEPTH)
	                                                      : item.byte_count;

	always_comb begin
		state_d = state_q;
		rc_d    = rc_q;
		wc_d    = wc_q;
		lbf_d   = lbf_q;
		dev_d   = dev_q;
		rga_d   = rga_q;
		cnt_d   = cnt_q;
		stat_d  = stat_q;
		res     = '0;
		wbuf_req.we    = 1'b0;
		wbuf_req.waddr = item.buf_index;
		wbuf_req.wdata = item.buf_value;

		if (fire) begin
			unique case (item.req_type)
				REQ_LOAD: begin
					wbuf_req.we = 1'b1;
				end
				REQ_RELEASE: begin
					stat_d = STAT_IDLE;
				end
				REQ_TICK: begin
					unique case (state_q)
						ST_IDLE: begin
							if (stat_q == STAT_IDLE &&
							    (item.cmd == CMD_READ || item.cmd == CMD_WRITE)) begin
								dev_d   = item.dev_addr;
								rga_d   = item.reg_addr;
								cnt_d   = cnt_sat;
								state_d = (item.cmd == CMD_READ) ? ST_RD_START : ST_WR_START;
							end
						end
						ST_RD_START: begin
							stat_d         = STAT_READING;
							res.bus_action = ACT_START_SEND;
							res.tx_byte    = dev_q;
							state_d        = ST_RD_WAIT_DEV;
						end
						ST_RD_WAIT_DEV: begin
							if (item.xfer_done) begin
								res.bus_action = ACT_CLEAR;
								state_d        = ST_RD_REG;
							end
						end
						ST_RD_REG: begin
							res.bus_action = ACT_SEND;
							res.tx_byte    = rga_q;
							state_d        = ST_RD_WAIT_REG;
						end
						ST_RD_WAIT_REG: begin
							if (item.xfer_done) begin
								res.bus_action = ACT_CLEAR;
								state_d        = ST_RD_RESTART;
							end
						end
						ST_RD_RESTART: begin
							res.bus_action = ACT_RESTART_SEND;
							res.tx_byte    = dev_q | DEV_READ_BIT;
							state_d        = ST_RD_WAIT_RS;
						end
						ST_RD_WAIT_RS: begin
							if (item.xfer_done) begin
								res.bus_action = ACT_CLEAR_RX;
								state_d        = ST_RD_ARM;
							end
						end
						ST_RD_ARM: begin
							if (rc_q < cnt_q) begin
								lbf_d          = (rc_inc == cnt_q);
								res.bus_action = (rc_inc == cnt_q) ? ACT_RX_NACK : ACT_RX_ACK;
								state_d        = ST_RD_WAIT_BYTE;
							end else begin
								state_d = ST_RD_FINISH;
							end
						end
						ST_RD_WAIT_BYTE: begin
							if (item.xfer_done) begin
								res.bus_action = ACT_CLEAR;
								state_d        = ST_RD_CAPTURE;
							end
						end
						ST_RD_CAPTURE: begin
							res.bus_action = lbf_q ? ACT_STOP_CAPTURE : ACT_CAPTURE;
							res.read_valid = 1'b1;
							res.read_index = rc_q[3:0];
							res.read_data  = item.rx_byte;
							rc_d           = rc_inc;
							state_d        = (rc_inc < cnt_q) ? ST_RD_ARM : ST_RD_FINISH;
						end
						ST_RD_FINISH: begin
							rc_d           = '0;
							stat_d         = STAT_READ_DONE;
							res.done_pulse = 1'b1;
							state_d        = ST_IDLE;
						end
						ST_WR_START: begin
							stat_d         = STAT_WRITING;
							res.bus_action = ACT_START_SEND;
							res.tx_byte    = dev_q;
							state_d        = ST_WR_WAIT_DEV;
						end
						ST_WR_WAIT_DEV: begin
							if (item.xfer_done) begin
								res.bus_action = ACT_CLEAR;
								state_d        = ST_WR_REG;
							end
						end
						ST_WR_REG: begin
							res.bus_action = ACT_SEND;
							res.tx_byte    = rga_q;
							state_d        = ST_WR_WAIT_REG;
						end
						ST_WR_WAIT_REG, ST_WR_WAIT_DATA: begin
							if (item.xfer_done) begin
								res.bus_action = ACT_CLEAR;
								state_d        = (wc_q < cnt_q) ? ST_WR_DATA : ST_WR_FINISH;
							end
						end
						ST_WR_DATA: begin
							// buffer output already holds the entry at wc_q
							res.bus_action = ACT_SEND;
							res.tx_byte    = wbuf_rdata;
							wc_d           = wc_q + 1'b1;
							state_d        = ST_WR_WAIT_DATA;
						end
						ST_WR_FINISH: begin
							res.bus_action = ACT_STOP;
							wc_d           = '0;
							stat_d         = STAT_WRITE_DONE;
							res.done_pulse = 1'b1;
							state_d        = ST_IDLE;
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end
				default: ;
			endcase
		end

		res.status     = stat_d;
		wbuf_req.raddr = wc_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rc_q    <= '0;
			wc_q    <= '0;
			lbf_q   <= 1'b0;
			dev_q   <= '0;
			rga_q   <= '0;
			cnt_q   <= '0;
			stat_q  <= STAT_IDLE;
		end else begin
			state_q <= state_d;
			rc_q    <= rc_d;
			wc_q    <= wc_d;
			lbf_q   <= lbf_d;
			dev_q   <= dev_d;
			rga_q   <= rga_d;
			cnt_q   <= cnt_d;
			stat_q  <= stat_d;
		end
	end

`ifndef SYNTHESIS
	a_rc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rc_q <= cnt_q)
		else $error("read counter passed latched count");

	a_wc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wc_q <= cnt_q)
		else $error("write counter passed latched count");

	a_cnt_sat: assert property (@(posedge clk) disable iff (!arst_n)
		int'(cnt_q) <= BUF_DEPTH)
		else $error("latched count exceeds buffer depth");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res.done_pulse |=> state_q == ST_IDLE && rc_q == '0 && wc_q == '0)
		else $error("finished transfer left counters or state busy");

	a_capture_act: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res.read_valid |->
			(res.bus_action == ACT_STOP_CAPTURE || res.bus_action == ACT_CAPTURE))
		else $error("received byte without a capture action");
`endif

endmodule
